/* hw/rtl/draw_list_delta_encoder_top_macros.svh */
// Assertion macros used by the draw list delta encoder checker.
`ifndef DRAW_LIST_DELTA_ENCODER_TOP_MACROS_SVH
`define DRAW_LIST_DELTA_ENCODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLDE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dlde_pkg.sv */
// Shared types and constants of the draw list delta encoder.
`default_nettype none

package dlde_pkg;

  localparam int unsigned CoordW      = 6;
  localparam int unsigned ColourW     = 4;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned TotalW      = 16;
  localparam int unsigned MaxBytes    = 7;
  localparam int unsigned CntW        = 3;
  localparam int unsigned MaxCoords   = 4;
  localparam int unsigned DefColumns  = 40;
  localparam int unsigned DefRows     = 48;

  localparam logic [ByteW-1:0] SetColorBase = 8'hC0;

  typedef enum logic [3:0] {
    KEnd   = 4'h0,
    KBox   = 4'h2,
    KHlin  = 4'h3,
    KVlin  = 4'h4,
    KPlot  = 4'h5,
    KHadd  = 4'h6,
    KHaddL = 4'h7,
    KHaddR = 4'h8,
    KBadd  = 4'h9,
    KBaddL = 4'hA,
    KBaddR = 4'hB,
    KVadd  = 4'hC
  } kind_e;

  typedef struct packed {
    logic [CoordW-1:0]  left_x;
    logic [CoordW-1:0]  top_y;
    logic [CoordW-1:0]  right_x;
    logic [CoordW-1:0]  bottom_y;
    logic [ColourW-1:0] colour;
    logic               frame_end;
  } item_t;

  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                cnt;
    logic                           fin;
  } list_t;

endpackage

`default_nettype wire

/* hw/rtl/dlde_classify.sv */
// Rectangle classifier with history registers that builds the byte list of one item.
`default_nettype none

module dlde_classify
  import dlde_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = DefColumns,
  parameter int unsigned SCREEN_ROWS    = DefRows
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire item_t item_i,
  input  wire logic  load_i,
  output list_t      list_o
);

  logic [CoordW-1:0]  l, t, r, b;
  kind_e              kind;
  logic               tnext, bnext;
  logic [MaxCoords-1:0][CoordW-1:0] crd;
  logic [CntW-1:0]    ncoord;
  logic [CntW-1:0]    pos;

  kind_e              prev_kind_q, prev_kind_d;
  kind_e              last_op_q, last_op_d;
  logic [ColourW-1:0] act_q, act_d;
  logic [CoordW-1:0]  prev_l_q, prev_r_q, prev_t_q, prev_b_q;
  logic [CoordW-1:0]  prev_l_d, prev_r_d, prev_t_d, prev_b_d;

  function automatic logic [CoordW-1:0] clamp(input logic [CoordW-1:0] v,
                                              input int unsigned lim);
    logic [CoordW:0] lim_w;
    lim_w = (CoordW+1)'(lim);
    return ({1'b0, v} >= lim_w) ? CoordW'(lim - 1) : v;
  endfunction

  assign l = clamp(item_i.left_x, SCREEN_COLUMNS);
  assign r = clamp(item_i.right_x, SCREEN_COLUMNS);
  assign t = clamp(item_i.top_y, SCREEN_ROWS);
  assign b = clamp(item_i.bottom_y, SCREEN_ROWS);

  assign tnext = ({1'b0, prev_t_q} + 1'b1) == {1'b0, t};
  assign bnext = ({1'b0, prev_b_q} + 1'b1) == {1'b0, t};

  always_comb begin
    if (l == r && t == b) begin
      kind = KPlot;
    end else if (l == r) begin
      kind = KVlin;
    end else if (t == b) begin
      kind = KHlin;
    end else begin
      kind = KBox;
    end
    if (kind == KHlin) begin
      if ((prev_kind_q inside {KHlin, KHadd, KHaddL}) && tnext && prev_l_q == l) begin
        kind = KHaddL;
      end else if ((prev_kind_q inside {KHlin, KHadd, KHaddR}) && tnext &&
                   prev_r_q == r) begin
        kind = KHaddR;
      end else if ((prev_kind_q inside {KHlin, KHadd, KPlot}) && tnext) begin
        kind = KHadd;
      end
    end else if (kind == KVlin) begin
      if ((prev_kind_q inside {KVlin, KVadd}) &&
          ({1'b0, prev_l_q} + 1'b1) == {1'b0, l}) begin
        kind = KVadd;
      end
    end else if (kind == KBox) begin
      if ((prev_kind_q inside {KBox, KBadd, KBaddL}) && bnext && prev_l_q == l) begin
        kind = KBaddL;
      end else if ((prev_kind_q inside {KBox, KBadd, KBaddR}) && bnext &&
                   prev_r_q == r) begin
        kind = KBaddR;
      end else if ((prev_kind_q inside {KBox, KBadd}) && bnext) begin
        kind = KBadd;
      end
    end
  end

  always_comb begin
    crd    = '0;
    ncoord = '0;
    case (kind)
      KBox:   begin crd = {b, r, t, l};          ncoord = 3'd4; end
      KHlin:  begin crd = {6'd0, t, r, l};       ncoord = 3'd3; end
      KVlin:  begin crd = {6'd0, b, t, l};       ncoord = 3'd3; end
      KPlot:  begin crd = {12'd0, t, l};         ncoord = 3'd2; end
      KVadd:  begin crd = {12'd0, b, t};         ncoord = 3'd2; end
      KHadd:  begin crd = {12'd0, r, l};         ncoord = 3'd2; end
      KHaddL: begin crd = {18'd0, r};            ncoord = 3'd1; end
      KHaddR: begin crd = {18'd0, l};            ncoord = 3'd1; end
      KBadd:  begin crd = {6'd0, b, r, l};       ncoord = 3'd3; end
      KBaddL: begin crd = {12'd0, b, r};         ncoord = 3'd2; end
      default: begin crd = {12'd0, b, l};        ncoord = 3'd2; end
    endcase
  end

  always_comb begin
    list_o = '0;
    pos    = '0;
    if (item_i.colour != '0) begin
      if (act_q != item_i.colour) begin
        list_o.bytes[pos] = SetColorBase | {4'd0, item_i.colour};
        pos = pos + 1'b1;
      end
      if (last_op_q != kind) begin
        list_o.bytes[pos] = {4'd0, kind};
        pos = pos + 1'b1;
      end
      for (int i = 0; i < MaxCoords; i++) begin
        if (CntW'(i) < ncoord) begin
          list_o.bytes[pos] = {2'd0, crd[i]};
          pos = pos + 1'b1;
        end
      end
    end
    if (item_i.frame_end) begin
      list_o.bytes[pos] = {4'd0, KEnd};
      pos = pos + 1'b1;
    end
    list_o.cnt = pos;
    list_o.fin = item_i.frame_end;
  end

  always_comb begin
    prev_kind_d = prev_kind_q;
    last_op_d   = last_op_q;
    act_d       = act_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    prev_t_d    = prev_t_q;
    prev_b_d    = prev_b_q;
    if (load_i) begin
      if (item_i.frame_end) begin
        prev_kind_d = KEnd;
        last_op_d   = KEnd;
        act_d       = '0;
        prev_l_d    = '0;
        prev_r_d    = '0;
        prev_t_d    = '0;
        prev_b_d    = '0;
      end else begin
        prev_kind_d = kind;
        prev_l_d    = l;
        prev_r_d    = r;
        prev_t_d    = t;
        prev_b_d    = b;
        if (item_i.colour != '0) begin
          act_d     = item_i.colour;
          last_op_d = kind;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_kind_q <= KEnd;
      last_op_q   <= KEnd;
      act_q       <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      prev_t_q    <= '0;
      prev_b_q    <= '0;
    end else begin
      prev_kind_q <= prev_kind_d;
      last_op_q   <= last_op_d;
      act_q       <= act_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      prev_t_q    <= prev_t_d;
      prev_b_q    <= prev_b_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dlde_serial.sv */
// Byte list shifter that sends one byte per cycle while out_stall_i is low and keeps the running byte total.
`default_nettype none

module dlde_serial
  import dlde_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire list_t             list_i,
  input  wire logic              load_i,
  output logic                   load_ok_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ByteW-1:0]       out_byte_o,
  output logic [TotalW-1:0]      running_total_o,
  output logic                   last_of_item_o,
  output logic                   frame_done_o
);

  logic [MaxBytes-1:0][ByteW-1:0] bytes_q, bytes_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           fin_q, fin_d;
  logic [TotalW-1:0]              total_q, total_d;
  logic [TotalW-1:0]              shown_q, shown_d;
  logic                           take;

  assign take        = (cnt_q != '0) && !out_stall_i;
  assign load_ok_o   = (cnt_q == '0) || (cnt_q == CntW'(1) && take);

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    total_d = total_q;
    if (take) begin
      total_d = (cnt_q == CntW'(1) && fin_q) ? '0 : shown_q;
      bytes_d = bytes_q >> ByteW;
      cnt_d   = cnt_q - 1'b1;
    end
    if (load_i) begin
      bytes_d = list_i.bytes;
      cnt_d   = list_i.cnt;
      fin_d   = list_i.fin;
    end
    shown_d = (total_d == '1) ? total_d : total_d + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      total_q <= '0;
      shown_q <= TotalW'(1);
    end else begin
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      total_q <= total_d;
      shown_q <= shown_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign out_valid_o     = cnt_q != '0;
  assign out_byte_o      = bytes_q[0];
  assign running_total_o = shown_q;
  assign last_of_item_o  = cnt_q == CntW'(1);
  assign frame_done_o    = (cnt_q == CntW'(1)) && fin_q;

endmodule

`default_nettype wire

/* hw/rtl/draw_list_delta_encoder_top.sv */
// Top level of the draw list delta encoder.
// The input channel takes one rectangle request per accepted cycle: left_x_i, top_y_i,
// right_x_i, bottom_y_i, colour_i and frame_end_i, with in_valid_i and in_stall_o.
// The output channel sends one byte of the encoded draw list per accepted cycle on
// out_byte_o, with running_total_o, last_of_item_o and frame_done_o beside it.
// A request is held in an input register, classified against the previous rectangle
// from there and loaded as a list of up to seven bytes into the output shifter.
// The first byte of a request appears once it has passed the input register and
// been loaded into the output shifter register. The output shifter sends one byte
// per cycle while out_stall_i is low, and a request that yields no byte sends none.
// The next request is loaded in the same cycle as the last byte of the previous one
// is taken, so a stream of requests that each yield bytes runs without gaps.
// When out_stall_i is high the current byte holds, and once the input register is
// also full in_stall_o rises.
// Reset clears the history, the running total and all valid flags; the end of a
// frame returns the history and the total to their reset values.
`default_nettype none

module draw_list_delta_encoder_top
  import dlde_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = DefColumns,
  parameter int unsigned SCREEN_ROWS    = DefRows
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CoordW-1:0]  left_x_i,
  input  wire logic [CoordW-1:0]  top_y_i,
  input  wire logic [CoordW-1:0]  right_x_i,
  input  wire logic [CoordW-1:0]  bottom_y_i,
  input  wire logic [ColourW-1:0] colour_i,
  input  wire logic               frame_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ByteW-1:0]        out_byte_o,
  output logic [TotalW-1:0]       running_total_o,
  output logic                    last_of_item_o,
  output logic                    frame_done_o
);

  item_t item_q;
  logic  in_valid_q, in_valid_d;
  logic  load_ok, load;
  list_t list;

  assign load       = in_valid_q && load_ok;
  assign in_stall_o = in_valid_q && !load_ok;

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b0;
    end
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= '{left_x: left_x_i, top_y: top_y_i, right_x: right_x_i,
                  bottom_y: bottom_y_i, colour: colour_i, frame_end: frame_end_i};
    end
  end

  dlde_classify #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_classify (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item_q),
    .load_i(load),
    .list_o(list)
  );

  dlde_serial u_serial (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .list_i         (list),
    .load_i         (load),
    .load_ok_o      (load_ok),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .running_total_o(running_total_o),
    .last_of_item_o (last_of_item_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/dlde_checker.sv */
// Port level checker of the draw list delta encoder and its bind to the top level.
`default_nettype none

`include "draw_list_delta_encoder_top_macros.svh"

module dlde_checker
  import dlde_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [ByteW-1:0]  out_byte_o,
  input wire logic [TotalW-1:0] running_total_o,
  input wire logic              last_of_item_o,
  input wire logic              frame_done_o
);

  // The end marker is a zero byte and always closes its request.
  `DLDE_ASSERT_SAME(a_end_byte, clk_i, rst_ni, out_valid_o && frame_done_o, last_of_item_o && out_byte_o == 8'h00, "frame end byte is not a last zero byte")

  // After the end byte is taken the total starts over.
  `DLDE_ASSERT_NEXT(a_total_restart, clk_i, rst_ni, out_valid_o && !out_stall_i && frame_done_o, running_total_o == 16'd1, "running total did not restart after frame end")

  // Bytes of one request follow without a gap and the total counts each of them.
  `DLDE_ASSERT_NEXT(a_total_step, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_of_item_o && running_total_o != 16'hFFFF, out_valid_o && running_total_o == $past(running_total_o) + 16'd1, "running total or byte sequence broken within a request")

  // A stalled byte stays in place.
  `DLDE_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o), "stalled output byte changed")

endmodule

bind draw_list_delta_encoder_top dlde_checker u_dlde_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .running_total_o(running_total_o),
  .last_of_item_o (last_of_item_o),
  .frame_done_o   (frame_done_o)
);

`default_nettype wire
